@@ sv/vvts_pkg.sv @@
// ----------------------------------------------------------------------------
// vvts_pkg
// Types and constants used by the vertical timing sequencer.
// ----------------------------------------------------------------------------
package vvts_pkg;

	// frame geometry defaults
	localparam int FRAME_LINES_DEF = 525;
	localparam int SYNC_LINES_DEF  = 2;

	// field and counter widths
	localparam int VIS_W   = 9;
	localparam int HRES_W  = 11;
	localparam int CNT_W   = 10;
	localparam int PTR_W   = 14;
	localparam int WORDS_W = 6;

	// limits and fixed numbers of the sequence
	localparam logic [VIS_W-1:0]  MAX_VISIBLE = 9'd480;
	localparam logic [HRES_W-1:0] MAX_HRES    = 11'd1024;
	localparam logic [8:0]        PRE_TRIM    = 9'd12;
	localparam logic [HRES_W:0]   WORD_ROUND  = 12'd31;
	localparam int                WORD_SHIFT  = 5;    // 32 pixels per word

	// configuration port
	localparam int APB_DATA_W = 32;
	localparam int APB_ADDR_W = 3;
	localparam int REG_IDX_W  = 1;
	localparam logic [REG_IDX_W-1:0] REG_VISIBLE_LINES = 1'd0;
	localparam logic [REG_IDX_W-1:0] REG_HRES_PIXELS   = 1'd1;

	// vertical phases in frame order
	typedef enum logic [1:0] {
		PH_BOTTOM  = 2'd0,
		PH_SYNC    = 2'd1,
		PH_TOP     = 2'd2,
		PH_VISIBLE = 2'd3
	} phase_t;

	// one line result
	typedef struct packed {
		logic             vsync_level;
		logic             line_visible;
		logic [PTR_W-1:0] line_word_offset;
		logic [1:0]       phase_now;
	} res_t;

endpackage

@@ sv/vvts_tick_if.sv @@
// ----------------------------------------------------------------------------
// vvts_tick_if
// Line tick request channel with valid/ready handshake.
// ----------------------------------------------------------------------------
interface vvts_tick_if;

	logic valid;
	logic ready;
	logic line_tick;

	modport source (output valid, output line_tick, input ready);
	modport sink   (input valid, input line_tick, output ready);

endinterface

@@ sv/vvts_line_if.sv @@
// ----------------------------------------------------------------------------
// vvts_line_if
// Per-line result channel with valid/ready handshake.
// ----------------------------------------------------------------------------
interface vvts_line_if;

	logic        valid;
	logic        ready;
	logic        vsync_level;
	logic        line_visible;
	logic [13:0] line_word_offset;
	logic [1:0]  phase_now;

	modport source (
		output valid, output vsync_level, output line_visible,
		output line_word_offset, output phase_now, input ready
	);
	modport sink (
		input valid, input vsync_level, input line_visible,
		input line_word_offset, input phase_now, output ready
	);

endinterface

@@ sv/vga_vertical_timing_sequencer.sv @@
// ----------------------------------------------------------------------------
// vga_vertical_timing_sequencer
// Steps bottom blank, sync, top blank and visible phases once per line tick
// and reports sync level, visibility and framebuffer word offset per line.
// ----------------------------------------------------------------------------
//
//  channel    dir   handshake            payload
//  tick_in    in    valid / ready        line_tick
//  line_out   out   valid / ready        vsync_level, line_visible,
//                                        line_word_offset, phase_now
//  apb        in    psel/penable/pready  visible_lines (0x0), hres_pixels (0x4)
//
// One request is taken per cycle while tick_in.ready is high; its result is
// registered in the output register, or in the skid register if the output
// is held. The phase/count/pointer update is combinational.
// A skid register behind the output register keeps tick_in.ready high while
// one result waits; ready drops only when both hold a result.
// arst_n clears phase to bottom blank, count to 1, pointer to 0, vsync high,
// and the registers to 480 lines and 640 pixels.
//
module vga_vertical_timing_sequencer #(
	parameter int FRAME_LINES = vvts_pkg::FRAME_LINES_DEF,
	parameter int SYNC_LINES  = vvts_pkg::SYNC_LINES_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	vvts_tick_if.sink                         tick_in,
	vvts_line_if.source                       line_out,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [vvts_pkg::APB_ADDR_W-1:0]   paddr,
	input  logic [vvts_pkg::APB_DATA_W-1:0]   pwdata,
	output logic [vvts_pkg::APB_DATA_W-1:0]   prdata,
	output logic                              pready
);
	import vvts_pkg::*;

	localparam logic [CNT_W-1:0] FRAME_C = CNT_W'(FRAME_LINES);
	localparam logic [CNT_W-1:0] SYNC_C  = CNT_W'(SYNC_LINES);

	// configuration registers
	logic [VIS_W-1:0]     visible_lines_q;
	logic [HRES_W-1:0]    hres_pixels_q;
	logic                 cfg_wr;
	logic [REG_IDX_W-1:0] reg_idx;

	// sequencer state
	phase_t           phase_q, phase_d;
	logic [CNT_W-1:0] lines_left_q, lines_left_d;
	logic [PTR_W-1:0] ptr_q, ptr_d;
	logic             vsync_q, vsync_d;

	// derived line counts
	logic [VIS_W-1:0]   vis_eff;
	logic [CNT_W-1:0]   blank;
	logic [8:0]         blank_half;
	logic [CNT_W-1:0]   pre_cnt;
	logic [CNT_W-1:0]   post_cnt;
	logic [HRES_W-1:0]  hres_eff;
	logic [HRES_W:0]    hres_round;
	logic [WORDS_W-1:0] words;

	// output register and skid stage
	res_t res_d, out_q, skid_q;
	logic out_valid_q, skid_valid_q;
	logic tick_acc, tick_fire, out_free;

	// config write and readback
	assign pready  = 1'b1;
	assign cfg_wr  = psel & penable & pwrite & pready;
	assign reg_idx = paddr[APB_ADDR_W-1:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			visible_lines_q <= MAX_VISIBLE;
			hres_pixels_q   <= 11'd640;
		end else if (cfg_wr) begin
			case (reg_idx)
				REG_VISIBLE_LINES: visible_lines_q <= pwdata[VIS_W-1:0];
				REG_HRES_PIXELS:   hres_pixels_q   <= pwdata[HRES_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_VISIBLE_LINES: prdata = APB_DATA_W'(visible_lines_q);
			REG_HRES_PIXELS:   prdata = APB_DATA_W'(hres_pixels_q);
			default:           prdata = '0;
		endcase
	end

	// visible count clamped to 1..480, blank split around the sync pulse
	always_comb begin
		if (visible_lines_q == '0)
			vis_eff = 9'd1;
		else if (visible_lines_q > MAX_VISIBLE)
			vis_eff = MAX_VISIBLE;
		else
			vis_eff = visible_lines_q;
		blank      = FRAME_C - CNT_W'(vis_eff) - SYNC_C;
		blank_half = blank[CNT_W-1:1];
		pre_cnt    = (blank_half > PRE_TRIM) ? CNT_W'(blank_half - PRE_TRIM)
		                                     : CNT_W'(1);
		post_cnt   = blank - pre_cnt;
	end

	// words per line, resolution clamped to 1024
	always_comb begin
		hres_eff   = (hres_pixels_q > MAX_HRES) ? MAX_HRES : hres_pixels_q;
		hres_round = {1'b0, hres_eff} + WORD_ROUND;
		words      = hres_round[WORD_SHIFT +: WORDS_W];
	end

	assign tick_in.ready = ~skid_valid_q;
	assign tick_acc      = tick_in.valid & tick_in.ready;
	assign tick_fire     = tick_acc & tick_in.line_tick;

	// phase work, line report and count-down
	always_comb begin
		phase_d      = phase_q;
		lines_left_d = lines_left_q;
		ptr_d        = ptr_q;
		vsync_d      = vsync_q;
		res_d.line_word_offset = '0;
		if (tick_fire) begin
			case (phase_q)
				PH_BOTTOM: ptr_d   = '0;
				PH_SYNC:   vsync_d = 1'b0;
				PH_TOP:    vsync_d = 1'b1;
				PH_VISIBLE: ptr_d  = ptr_q + PTR_W'(words);
				default: ;
			endcase
			if (lines_left_q <= CNT_W'(1)) begin
				case (phase_q)
					PH_BOTTOM:  lines_left_d = SYNC_C;
					PH_SYNC:    lines_left_d = post_cnt;
					PH_TOP:     lines_left_d = CNT_W'(vis_eff);
					PH_VISIBLE: lines_left_d = pre_cnt;
					default:    lines_left_d = CNT_W'(1);
				endcase
				phase_d = phase_t'(phase_q + 2'd1);
			end else begin
				lines_left_d = lines_left_q - CNT_W'(1);
			end
		end
		res_d.vsync_level  = vsync_d;
		res_d.line_visible = (phase_q == PH_VISIBLE);
		res_d.phase_now    = phase_q;
		if (phase_q == PH_VISIBLE)
			res_d.line_word_offset = ptr_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_BOTTOM;
			lines_left_q <= CNT_W'(1);
			ptr_q        <= '0;
			vsync_q      <= 1'b1;
		end else begin
			phase_q      <= phase_d;
			lines_left_q <= lines_left_d;
			ptr_q        <= ptr_d;
			vsync_q      <= vsync_d;
		end
	end

	// output register with skid stage behind it
	assign out_free = ~out_valid_q | line_out.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q  <= skid_valid_q | tick_acc;
			skid_valid_q <= 1'b0;
		end else if (tick_acc) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			out_q <= skid_valid_q ? skid_q : res_d;
		end else if (tick_acc) begin
			skid_q <= res_d;
		end
	end

	assign line_out.valid            = out_valid_q;
	assign line_out.vsync_level      = out_q.vsync_level;
	assign line_out.line_visible     = out_q.line_visible;
	assign line_out.line_word_offset = out_q.line_word_offset;
	assign line_out.phase_now        = out_q.phase_now;

	// skid stage only fills behind a held output
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid holds a result while output register is empty");

	// sync level is low only around the sync phase
	a_vsync_phase: assert property (@(posedge clk) disable iff (!arst_n)
		!vsync_q |-> (phase_q == PH_SYNC || phase_q == PH_TOP))
		else $error("vsync low outside sync and top blank");

	// bottom blank line rewinds the pointer
	a_rewind: assert property (@(posedge clk) disable iff (!arst_n)
		(tick_fire && phase_q == PH_BOTTOM) |=> (ptr_q == '0))
		else $error("pointer not rewound in bottom blank");

	// line count never runs empty
	a_count_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		lines_left_q != '0)
		else $error("line count reached zero");

endmodule
